### sv/irl_pkg.sv
// Shared constants, register codes and distance tables for the IR range linearizer.
package irl_pkg;

   localparam int ADC_BITS_DEF = 10;
   localparam int CNT_W        = 8;
   localparam int MODEL_W      = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int AVG_W        = 10;
   localparam int DIST_W       = 8;
   localparam int BOUND_W      = 10;
   localparam int TBL_IDX_W    = 7;
   localparam int SRCH_STEPS   = 7;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_MODEL = 2'd1;

   localparam logic [MODEL_W-1:0] MODEL_LONG  = 2'd1;
   localparam logic [MODEL_W-1:0] MODEL_SHORT = 2'd2;

   localparam logic [DIST_W-1:0] DIST_NO_TABLE = 8'd200;
   localparam logic [DIST_W-1:0] DIST_BEYOND   = 8'd0;

   localparam int LONG_LEN  = 73;
   localparam int SHORT_LEN = 44;

   localparam logic [BOUND_W-1:0] LONG_BOUND [LONG_LEN] = '{
      10'd60,  10'd63,  10'd71,  10'd72,  10'd73,  10'd74,  10'd75,  10'd76,
      10'd77,  10'd78,  10'd79,  10'd80,  10'd81,  10'd82,  10'd83,  10'd84,
      10'd85,  10'd87,  10'd88,  10'd89,  10'd90,  10'd92,  10'd93,  10'd94,
      10'd96,  10'd97,  10'd99,  10'd100, 10'd102, 10'd104, 10'd106, 10'd107,
      10'd109, 10'd111, 10'd113, 10'd115, 10'd118, 10'd120, 10'd122, 10'd125,
      10'd128, 10'd130, 10'd133, 10'd136, 10'd140, 10'd143, 10'd147, 10'd150,
      10'd154, 10'd158, 10'd163, 10'd168, 10'd173, 10'd178, 10'd184, 10'd190,
      10'd196, 10'd204, 10'd211, 10'd220, 10'd229, 10'd239, 10'd250, 10'd262,
      10'd275, 10'd290, 10'd307, 10'd326, 10'd347, 10'd373, 10'd402, 10'd437,
      10'd639
   };

   localparam logic [DIST_W-1:0] LONG_DIST [LONG_LEN] = '{
      8'd90, 8'd85, 8'd80, 8'd79, 8'd78, 8'd77, 8'd75, 8'd74,
      8'd73, 8'd72, 8'd71, 8'd70, 8'd69, 8'd68, 8'd67, 8'd66,
      8'd65, 8'd64, 8'd63, 8'd62, 8'd61, 8'd60, 8'd59, 8'd58,
      8'd57, 8'd56, 8'd55, 8'd54, 8'd53, 8'd52, 8'd51, 8'd50,
      8'd49, 8'd48, 8'd47, 8'd46, 8'd45, 8'd44, 8'd43, 8'd42,
      8'd41, 8'd40, 8'd39, 8'd38, 8'd37, 8'd36, 8'd35, 8'd34,
      8'd33, 8'd32, 8'd31, 8'd30, 8'd29, 8'd28, 8'd27, 8'd26,
      8'd25, 8'd24, 8'd23, 8'd22, 8'd21, 8'd20, 8'd19, 8'd18,
      8'd17, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd11, 8'd10,
      8'd5
   };

   localparam logic [BOUND_W-1:0] SHORT_BOUND [SHORT_LEN] = '{
      10'd27,  10'd33,  10'd40,  10'd48,  10'd50,  10'd52,  10'd53,  10'd55,
      10'd57,  10'd58,  10'd60,  10'd63,  10'd64,  10'd67,  10'd69,  10'd72,
      10'd77,  10'd79,  10'd80,  10'd84,  10'd88,  10'd92,  10'd96,  10'd100,
      10'd106, 10'd114, 10'd121, 10'd126, 10'd133, 10'd142, 10'd149, 10'd161,
      10'd173, 10'd186, 10'd198, 10'd217, 10'd238, 10'd265, 10'd291, 10'd326,
      10'd383, 10'd424, 10'd519, 10'd606
   };

   localparam logic [DIST_W-1:0] SHORT_DIST [SHORT_LEN] = '{
      8'd70, 8'd60, 8'd50, 8'd45, 8'd42, 8'd41, 8'd40, 8'd39,
      8'd38, 8'd37, 8'd36, 8'd35, 8'd34, 8'd33, 8'd32, 8'd31,
      8'd30, 8'd29, 8'd28, 8'd27, 8'd26, 8'd25, 8'd24, 8'd23,
      8'd22, 8'd21, 8'd20, 8'd19, 8'd18, 8'd17, 8'd16, 8'd15,
      8'd14, 8'd13, 8'd12, 8'd11, 8'd10, 8'd9,  8'd8,  8'd7,
      8'd6,  8'd5,  8'd4,  8'd3
   };

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_SEARCH,
      BK_LOOKUP,
      BK_HOLD
   } irl_back_state_type;

   // Number of entries in the selected table (zero when no table).
   function automatic logic [TBL_IDX_W-1:0] tbl_len(input logic [MODEL_W-1:0] model);
      logic [TBL_IDX_W-1:0] len;
      len = '0;
      if (model == MODEL_LONG) begin
         len = TBL_IDX_W'(LONG_LEN);
      end else if (model == MODEL_SHORT) begin
         len = TBL_IDX_W'(SHORT_LEN);
      end
      return len;
   endfunction

   // Bound of one entry; entries past the end read as zero and are never used.
   function automatic logic [BOUND_W-1:0] tbl_bound(input logic [MODEL_W-1:0] model,
                                                    input logic [TBL_IDX_W-1:0] idx);
      logic [BOUND_W-1:0] bound;
      bound = '0;
      if (model == MODEL_LONG && idx < TBL_IDX_W'(LONG_LEN)) begin
         bound = LONG_BOUND[idx];
      end else if (model == MODEL_SHORT && idx < TBL_IDX_W'(SHORT_LEN)) begin
         bound = SHORT_BOUND[idx[5:0]];
      end
      return bound;
   endfunction

   function automatic logic [DIST_W-1:0] tbl_dist(input logic [MODEL_W-1:0] model,
                                                  input logic [TBL_IDX_W-1:0] idx);
      logic [DIST_W-1:0] cm;
      cm = DIST_NO_TABLE;
      if (model == MODEL_LONG) begin
         cm = (idx < TBL_IDX_W'(LONG_LEN)) ? LONG_DIST[idx] : DIST_BEYOND;
      end else if (model == MODEL_SHORT) begin
         cm = (idx < TBL_IDX_W'(SHORT_LEN)) ? SHORT_DIST[idx[5:0]] : DIST_BEYOND;
      end
      return cm;
   endfunction

endpackage

### sv/ir_range_average_linearizer.sv
// Top level of the IR range average linearizer: registers, accumulator, queue, engine.
//
// Samples arrive as beats on req_ and are summed over a window of sample_count
// beats (zero counts as one). The beat that closes a window produces one rsp_
// beat holding the truncated mean and the distance in centimetres from the
// selected threshold table (long range, short range, or 200 when no table is
// selected); the other sample beats produce nothing. Sample beats are taken
// one per clock while the two-entry window queue has room. Each closed window
// then passes in turn through the bit-serial divider, the binary table search,
// the distance lookup and the output hold until the rsp_ beat is taken; only
// then does the engine pop the next window from the queue. Configuration
// writes on csr_ take effect at the next clock; a write to an index past
// sensor_model is dropped.
module ir_range_average_linearizer import irl_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((ADC_BITS + 7) / 8) * 8-1:0] req_tdata,  // [ADC_BITS-1:0] adc_sample
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // [9:0] average_level,
                                                           // [17:10] distance_cm
   // Register write port
   input  logic                                csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_wdata
);

   localparam int SUM_W = ADC_BITS + 8;
   localparam int JOB_W = SUM_W + CNT_W;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [MODEL_W-1:0] model_ff, model_in;

   logic               job_push;
   logic [SUM_W-1:0]   job_sum_push;
   logic [CNT_W-1:0]   job_taken_push;
   logic               job_full;
   logic               job_pop;
   logic               job_empty;
   logic [JOB_W-1:0]   job_head;

   logic [AVG_W-1:0]   rsp_average;
   logic [DIST_W-1:0]  rsp_distance;

   // Register file: latch the write, drop indexes past the last register.
   always_comb begin
      count_in = count_ff;
      model_in = model_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_SAMPLE_COUNT) begin
            count_in = csr_wdata[CNT_W-1:0];
         end else if (csr_index == CSR_SENSOR_MODEL) begin
            model_in = csr_wdata[MODEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
         model_ff <= MODEL_LONG;
      end else begin
         count_ff <= count_in;
         model_ff <= model_in;
      end
   end

   // Accumulate samples; push each closed window as a divide job.
   irl_front #(
      .ADC_BITS(ADC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_sample   (req_tdata[ADC_BITS-1:0]),
      .sample_count(count_ff),
      .job_full    (job_full),
      .job_push    (job_push),
      .job_sum     (job_sum_push),
      .job_taken   (job_taken_push)
   );

   // Hold closed windows while the engine is busy.
   irl_queue #(
      .DATA_W(JOB_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data({job_sum_push, job_taken_push}),
      .full     (job_full),
      .pop      (job_pop),
      .pop_data (job_head),
      .empty    (job_empty)
   );

   // Divide, search the table, and hold the result until the beat is taken.
   irl_back #(
      .ADC_BITS(ADC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (!job_empty),
      .job_pop     (job_pop),
      .job_sum     (job_head[JOB_W-1:CNT_W]),
      .job_taken   (job_head[CNT_W-1:0]),
      .sensor_model(model_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_average (rsp_average),
      .out_distance(rsp_distance)
   );

   assign rsp_tdata = {6'b0, rsp_distance, rsp_average};

endmodule

### sv/irl_front.sv
// Sample accumulator: sums samples per window and queues each closed window.
module irl_front import irl_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ADC_BITS-1:0]   in_sample,
   input  logic [CNT_W-1:0]      sample_count,
   input  logic                  job_full,
   output logic                  job_push,
   output logic [ADC_BITS+7:0]   job_sum,
   output logic [CNT_W-1:0]      job_taken
);

   localparam int SUM_W = ADC_BITS + 8;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [CNT_W:0]   taken_next;
   logic [CNT_W:0]   count_eff;
   logic             accept;
   logic             close;

   assign in_ready   = !job_full;
   assign accept     = in_valid && in_ready;
   assign count_eff  = (sample_count == '0) ? (CNT_W+1)'(1) : {1'b0, sample_count};
   assign taken_next = {1'b0, taken_ff} + (CNT_W+1)'(1);
   assign close      = taken_next >= count_eff;

   always_comb begin
      sum_in   = sum_ff;
      taken_in = taken_ff;
      if (accept) begin
         if (close) begin
            sum_in   = '0;
            taken_in = '0;
         end else begin
            sum_in   = sum_ff + SUM_W'(in_sample);
            taken_in = taken_next[CNT_W-1:0];
         end
      end
   end

   assign job_push  = accept && close;
   assign job_sum   = sum_ff + SUM_W'(in_sample);
   assign job_taken = taken_next[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         taken_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
      end
   end

endmodule

### sv/irl_queue.sv
// Short job queue between the accumulator and the divide/search engine.
module irl_queue import irl_pkg::*; #(
   parameter int DATA_W = ADC_BITS_DEF + 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign full     = fill_ff == FILL_W'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### sv/irl_back.sv
// Window engine: bit-serial divide, binary table search, result register.
module irl_back import irl_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_pop,
   input  logic [ADC_BITS+7:0] job_sum,
   input  logic [CNT_W-1:0]    job_taken,
   input  logic [MODEL_W-1:0]  sensor_model,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [AVG_W-1:0]    out_average,
   output logic [DIST_W-1:0]   out_distance
);

   localparam int SUM_W  = ADC_BITS + 8;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int CMP_W  = (ADC_BITS > BOUND_W) ? ADC_BITS : BOUND_W;
   localparam int BIT_W  = $clog2(SRCH_STEPS);

   irl_back_state_type state_ff, state_in;

   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TBL_IDX_W-1:0] pos_ff, pos_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;

   logic [CNT_W:0]       trial;
   logic                 trial_ge;
   logic [ADC_BITS-1:0]  level;
   logic [TBL_IDX_W-1:0] probe;
   logic                 probe_below;

   // Restoring divide step: shift in the next dividend bit, subtract if it fits.
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge = trial >= {1'b0, div_ff};

   // Binary search: count entries whose bound lies below the average.
   assign level       = quo_ff[ADC_BITS-1:0];
   assign probe       = pos_ff + ((TBL_IDX_W'(1) << bit_ff) - TBL_IDX_W'(1));
   assign probe_below = (probe < tbl_len(sensor_model)) &&
                        (CMP_W'(tbl_bound(sensor_model, probe)) < CMP_W'(level));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = BK_SEARCH;
            end
         end
         BK_SEARCH: begin
            if (bit_ff == '0) begin
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            state_in = BK_HOLD;
         end
         BK_HOLD: begin
            if (out_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      job_pop   = 1'b0;
      out_valid = 1'b0;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      bit_in    = bit_ff;
      avg_in    = avg_ff;
      dist_in   = dist_ff;
      unique case (state_ff)
         BK_IDLE: begin
            job_pop = job_valid;
            quo_in  = job_sum;
            div_in  = job_taken;
            rem_in  = '0;
            step_in = '0;
         end
         BK_DIVIDE: begin
            quo_in  = {quo_ff[SUM_W-2:0], trial_ge};
            rem_in  = trial_ge ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
            step_in = step_ff + STEP_W'(1);
            pos_in  = '0;
            bit_in  = BIT_W'(SRCH_STEPS - 1);
         end
         BK_SEARCH: begin
            if (probe_below) begin
               pos_in = probe + TBL_IDX_W'(1);
            end
            bit_in = bit_ff - BIT_W'(1);
         end
         BK_LOOKUP: begin
            avg_in  = AVG_W'(level);
            dist_in = tbl_dist(sensor_model, pos_ff);
         end
         BK_HOLD: begin
            out_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign out_average  = avg_ff;
   assign out_distance = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      bit_ff  <= bit_in;
      avg_ff  <= avg_in;
      dist_ff <= dist_in;
   end

endmodule

### bench/irl_bench_pkg.sv
// Distance tables and the window scoreboard used by the linearizer bench.
package irl_bench_pkg;
   import irl_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [7:0] NO_TABLE_CM = 8'd200;
   localparam logic [7:0] BEYOND_CM   = 8'd0;

   localparam int LR_COUNT = 73;
   localparam int SR_COUNT = 44;

   // Inclusive upper levels and their distances, ascending
   localparam int LR_LEVEL [LR_COUNT] = '{
      60, 63, 71, 72, 73, 74, 75, 76, 77, 78, 79, 80, 81, 82, 83, 84,
      85, 87, 88, 89, 90, 92, 93, 94, 96, 97, 99, 100, 102, 104, 106, 107,
      109, 111, 113, 115, 118, 120, 122, 125, 128, 130, 133, 136, 140, 143, 147, 150,
      154, 158, 163, 168, 173, 178, 184, 190, 196, 204, 211, 220, 229, 239, 250, 262,
      275, 290, 307, 326, 347, 373, 402, 437, 639
   };
   localparam int LR_CM [LR_COUNT] = '{
      90, 85, 80, 79, 78, 77, 75, 74, 73, 72, 71, 70, 69, 68, 67, 66,
      65, 64, 63, 62, 61, 60, 59, 58, 57, 56, 55, 54, 53, 52, 51, 50,
      49, 48, 47, 46, 45, 44, 43, 42, 41, 40, 39, 38, 37, 36, 35, 34,
      33, 32, 31, 30, 29, 28, 27, 26, 25, 24, 23, 22, 21, 20, 19, 18,
      17, 16, 15, 14, 13, 12, 11, 10, 5
   };
   localparam int SR_LEVEL [SR_COUNT] = '{
      27, 33, 40, 48, 50, 52, 53, 55, 57, 58, 60, 63, 64, 67, 69, 72,
      77, 79, 80, 84, 88, 92, 96, 100, 106, 114, 121, 126, 133, 142, 149, 161,
      173, 186, 198, 217, 238, 265, 291, 326, 383, 424, 519, 606
   };
   localparam int SR_CM [SR_COUNT] = '{
      70, 60, 50, 45, 42, 41, 40, 39, 38, 37, 36, 35, 34, 33, 32, 31,
      30, 29, 28, 27, 26, 25, 24, 23, 22, 21, 20, 19, 18, 17, 16, 15,
      14, 13, 12, 11, 10, 9, 8, 7, 6, 5, 4, 3
   };

   typedef struct packed {
      logic [9:0] level;
      logic [7:0] cm;
   } window_result_type;

   class irl_scoreboard;
      logic [7:0]        window_len;
      logic [1:0]        model;
      logic [17:0]       acc;
      logic [7:0]        acc_n;
      window_result_type due_q[$];
      int unsigned       failures;

      function new();
         window_len = 8'd1;
         model      = MODEL_LONG;
         acc        = '0;
         acc_n      = '0;
         failures   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
         if (idx == CSR_SAMPLE_COUNT) begin
            window_len = val;
         end else if (idx == CSR_SENSOR_MODEL) begin
            model = val[1:0];
         end
      endfunction

      function logic [7:0] range_cm(logic [9:0] level);
         if (model == MODEL_LONG) begin
            for (int i = 0; i < LR_COUNT; i++) begin
               if (int'(level) <= LR_LEVEL[i]) return 8'(LR_CM[i]);
            end
            return BEYOND_CM;
         end
         if (model == MODEL_SHORT) begin
            for (int i = 0; i < SR_COUNT; i++) begin
               if (int'(level) <= SR_LEVEL[i]) return 8'(SR_CM[i]);
            end
            return BEYOND_CM;
         end
         return NO_TABLE_CM;
      endfunction

      // Accumulate one sample; close the window once the count is reached.
      function void add_sample(logic [9:0] sample);
         logic [8:0]        taken;
         logic [8:0]        need;
         window_result_type res;
         acc   = acc + 18'(sample);
         taken = 9'(acc_n) + 9'd1;
         need  = (window_len == 8'd0) ? 9'd1 : 9'(window_len);
         if (taken < need) begin
            acc_n = taken[7:0];
         end else begin
            res.level = 10'(acc / 18'(taken));
            res.cm    = range_cm(res.level);
            due_q.push_back(res);
            acc   = '0;
            acc_n = '0;
         end
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic [9:0] level, logic [7:0] cm);
         window_result_type want;
         if (due_q.size() == 0) begin
            note_failure($sformatf("unexpected result beat: level %0d dist %0d", level, cm));
            return;
         end
         want = due_q.pop_front();
         if (want.level !== level || want.cm !== cm) begin
            note_failure($sformatf("result mismatch: expected level %0d dist %0d, got level %0d dist %0d",
                                   want.level, want.cm, level, cm));
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

endpackage

### bench/ir_range_average_linearizer_test.sv
// Top-level bench for the IR range average linearizer: stimulus, handshakes and checking.
module ir_range_average_linearizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import irl_pkg::*;
   import irl_bench_pkg::*;

   // Cycles to let the engine go quiet after the last result before a register write
   localparam int SETTLE_CYCLES = 100;
   // Cycles without any accepted beat before the run is declared hung
   localparam int QUIET_LIMIT   = 3000;
   // Length of the long result-side hold-off
   localparam int HOLD_CYCLES   = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [9:0] adc_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [9:0] average_level, [17:10] distance_cm
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_rsp       = 1'b0;
   int unsigned quiet_cycles   = 0;

   irl_scoreboard sb;

   ir_range_average_linearizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: stall at random, or hold off entirely while hold_rsp is set.
   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Sample result beats at the rising edge; also watch for a hung block.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata[9:0], rsp_tdata[17:10]);
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one sample beat, idling first at the sender's rate; keep tvalid high
   // across back-to-back beats and note the sample once it is accepted.
   task automatic push_sample(input logic [9:0] level);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, level};
      do @(posedge clock); while (!req_tready);
      sb.add_sample(level);
   endtask

   // Drop tvalid, wait for every expected result, then let the engine go quiet.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; only called while the block is idle.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Pick the idling mode: none, sender idle, receiver stalling, or both.
   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
         default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
   endtask

   // Mix full-scale samples with ones near the table region and the rails.
   function automatic logic [9:0] rand_sample();
      case ($urandom_range(3))
         0: return 10'($urandom_range(1023));
         1: return 10'($urandom_range(700));
         2: return 10'($urandom_range(120));
         default: return 10'($urandom_range(1023, 900));
      endcase
   endfunction

   // Mostly short windows so results come often; a few long ones and zero.
   function automatic logic [7:0] rand_window();
      case ($urandom_range(7))
         0: return 8'd0;
         1, 2: return 8'd1;
         3: return 8'd2;
         4: return 8'($urandom_range(5, 3));
         5: return 8'($urandom_range(16, 6));
         6: return 8'($urandom_range(40, 17));
         default: return 8'($urandom_range(255, 1));
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: long-range table edges, one sample per window
      csr_write(CSR_SAMPLE_COUNT, 8'd1);
      csr_write(CSR_SENSOR_MODEL, 8'(MODEL_LONG));
      push_sample(10'd0);
      push_sample(10'd60);
      push_sample(10'd61);
      push_sample(10'd63);
      push_sample(10'd437);
      push_sample(10'd438);
      push_sample(10'd639);
      push_sample(10'd640);
      push_sample(10'd1023);

      // Short-range table edges
      drain_results();
      csr_write(CSR_SENSOR_MODEL, 8'(MODEL_SHORT));
      push_sample(10'd27);
      push_sample(10'd28);
      push_sample(10'd606);
      push_sample(10'd607);
      push_sample(10'd1023);
      push_sample(10'd0);

      // No table: model zero, then three written with the upper data bits set
      drain_results();
      csr_write(CSR_SENSOR_MODEL, 8'd0);
      push_sample(10'd512);
      drain_results();
      csr_write(CSR_SENSOR_MODEL, 8'hFF);
      push_sample(10'd1023);

      // Writes past the last register must leave the model alone
      drain_results();
      csr_write(CSR_SPARE_LO, 8'h01);
      csr_write(CSR_SPARE_HI, 8'h02);
      push_sample(10'd100);

      // Zero count behaves as one
      drain_results();
      csr_write(CSR_SAMPLE_COUNT, 8'd0);
      csr_write(CSR_SENSOR_MODEL, 8'(MODEL_LONG));
      push_sample(10'd300);
      push_sample(10'd700);

      // Partial window survives a write; lowering the count closes it on the
      // next sample with the true number of samples as divisor
      drain_results();
      csr_write(CSR_SAMPLE_COUNT, 8'd4);
      push_sample(10'd1000);
      push_sample(10'd1010);
      push_sample(10'd1020);
      drain_results();
      csr_write(CSR_SAMPLE_COUNT, 8'd2);
      push_sample(10'd2);

      // Random phases, cycling through the idling modes
      for (int ph = 0; ph < 12; ph++) begin
         int unsigned n_items;
         logic [7:0]  len;
         drain_results();
         set_idling(ph % 4);
         len     = rand_window();
         n_items = 90;
         if (ph == 2) len = 8'd1;      // back-pressure phase: fill the queue fast
         if (ph == 5) begin             // one full-length window, every odd sample at full scale
            len     = 8'd255;
            n_items = 255;
         end
         csr_write(CSR_SAMPLE_COUNT, len);
         csr_write(CSR_SENSOR_MODEL, 8'($urandom_range(255)));
         if ($urandom_range(2) == 0) begin
            csr_write($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, 8'($urandom_range(255)));
         end
         if (ph == 2) begin
            // Hold off the result side for a long stretch while samples keep coming
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (HOLD_CYCLES) @(negedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         for (int i = 0; i < n_items; i++) begin
            push_sample((ph == 5 && i[0]) ? 10'd1023 : rand_sample());
         end
      end

      drain_results();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
